// ----- hw/rtl/pia_pkg.sv -----
package pia_pkg;

	localparam int NUM_LEVELS_DEF = 17;
	localparam int LEVEL_W        = 5;
	localparam int CODE_W         = 32;
	localparam int MASK_W         = 4;
	localparam int ADDR_W         = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [ADDR_W-1:0] HANDLER_OFFSET = 32'h0000_0600;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VECTOR_BASE = 2'd0,
		CFG_NMI_BLOCKED = 2'd1,
		CFG_IRL_MODE    = 2'd2
	} cfg_idx_t;

	localparam logic ACT_LINE   = 1'b0;
	localparam logic ACT_ACCEPT = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] vector_base;
		logic              nmi_when_blocked;
		logic              irl_mode;
	} cfg_t;

	typedef struct packed {
		logic               action;
		logic [LEVEL_W-1:0] level;
		logic               line_raised;
		logic [CODE_W-1:0]  event_code;
		logic [MASK_W-1:0]  mask_level;
		logic               block_bit;
	} item_t;

	typedef struct packed {
		logic               taken;
		logic [LEVEL_W-1:0] taken_level;
		logic [CODE_W-1:0]  taken_code;
		logic [ADDR_W-1:0]  handler_address;
		logic               mode_error;
		logic               pending;
		logic               nmi_flag;
	} res_t;

endpackage

// ----- hw/rtl/pia_cfg.sv -----
module pia_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [pia_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [pia_pkg::CFG_DATA_W-1:0]   wr_data,
	output pia_pkg::cfg_t                    cfg
);
	import pia_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_VECTOR_BASE: begin
					cfg_q.vector_base <= wr_data[ADDR_W-1:0];
				end
				CFG_NMI_BLOCKED: begin
					cfg_q.nmi_when_blocked <= wr_data[0];
				end
				CFG_IRL_MODE: begin
					cfg_q.irl_mode <= wr_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/pia_levels.sv -----
module pia_levels #(
	parameter int NUM_LEVELS = pia_pkg::NUM_LEVELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	input  pia_pkg::item_t  item,
	input  pia_pkg::cfg_t   cfg,
	output pia_pkg::res_t   res
);
	import pia_pkg::*;

	localparam int IDX_W = $clog2(NUM_LEVELS);
	localparam int NMI   = NUM_LEVELS - 1;

	logic [NUM_LEVELS-1:0] raised_q;
	logic [CODE_W-1:0]     code_q [NUM_LEVELS];
	logic                  nmi_seen_q;

	logic                  hit;
	logic [IDX_W-1:0]      hit_lv;
	logic                  is_accept;
	logic                  pend_cur;
	logic                  found;
	logic                  do_take;
	logic                  line_wr;
	logic [IDX_W-1:0]      line_idx;
	logic [NUM_LEVELS-1:0] raised_nxt;
	logic                  block_eff;
	logic                  any_nxt;
	logic                  pend_nxt;
	logic                  nmi_seen_nxt;

	// highest raised level above mask
	always_comb begin
		hit    = 1'b0;
		hit_lv = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (raised_q[i] && (i > int'(item.mask_level))) begin
				hit    = 1'b1;
				hit_lv = IDX_W'(i);
			end
		end
	end

	assign is_accept = (item.action == ACT_ACCEPT);
	assign pend_cur  = (raised_q[NMI] && (!item.block_bit || cfg.nmi_when_blocked)) ||
		(!item.block_bit && hit);
	assign found     = is_accept && pend_cur && hit;
	assign do_take   = found && cfg.irl_mode;
	assign line_wr   = !is_accept && (int'(item.level) < NUM_LEVELS);
	assign line_idx  = item.level[IDX_W-1:0];

	always_comb begin
		raised_nxt = raised_q;
		if (line_wr) begin
			raised_nxt[line_idx] = item.line_raised;
		end else if (do_take) begin
			raised_nxt[hit_lv] = 1'b0;
		end
	end

	assign block_eff = do_take | item.block_bit;

	always_comb begin
		any_nxt = 1'b0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (raised_nxt[i] && (i > int'(item.mask_level))) begin
				any_nxt = 1'b1;
			end
		end
	end

	assign pend_nxt = (raised_nxt[NMI] && (!block_eff || cfg.nmi_when_blocked)) ||
		(!block_eff && any_nxt);
	assign nmi_seen_nxt = nmi_seen_q | (line_wr && (int'(item.level) == NMI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raised_q   <= '0;
			nmi_seen_q <= 1'b0;
		end else if (valid) begin
			raised_q   <= raised_nxt;
			nmi_seen_q <= nmi_seen_nxt;
		end
	end

	// code is only read for a raised level, which a line word always wrote
	always_ff @(posedge clk) begin
		if (valid && line_wr) begin
			code_q[line_idx] <= item.event_code;
		end
	end

	always_comb begin
		res                 = '0;
		res.taken           = do_take;
		res.taken_level     = do_take ? LEVEL_W'(hit_lv) : '0;
		res.taken_code      = do_take ? code_q[hit_lv] : '0;
		res.handler_address = do_take ? (cfg.vector_base + HANDLER_OFFSET) : '0;
		res.mode_error      = found && !cfg.irl_mode;
		res.pending         = pend_nxt;
		res.nmi_flag        = nmi_seen_nxt;
	end

	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		valid && do_take |=> !raised_q[$past(hit_lv)])
		else $error("taken level still raised");

	a_take_legal: assert property (@(posedge clk) disable iff (!arst_n)
		do_take |-> raised_q[hit_lv] && (int'(hit_lv) > int'(item.mask_level)))
		else $error("taken level not raised above mask");

	a_nmi_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		nmi_seen_q |=> nmi_seen_q)
		else $error("nmi flag cleared");

	a_take_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		do_take && !cfg.nmi_when_blocked |-> !pend_nxt)
		else $error("pending after take without nmi override");

endmodule

// ----- hw/rtl/priority_interrupt_acceptor_top.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// item     | start & !busy              | action level line_raised event_code
//          |                            | mask_level block_bit
// config   | cfg_valid & cfg_ready      | cfg_index cfg_data
// result   | done (one-cycle strobe)    | taken taken_level taken_code
//          |                            | handler_address mode_error pending nmi_flag
//
// One word per cycle; busy is never raised. A word accepted at an edge passes
// the input register, then the level flags update and the priority encoder
// feed the result register, which raises done together with the result.
// cfg_ready is always high; write config only while no word is in flight.
// arst_n clears flags, config and strobes. The receiver cannot stall.
module priority_interrupt_acceptor_top #(
	parameter int NUM_LEVELS = pia_pkg::NUM_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             action,
	input  logic [pia_pkg::LEVEL_W-1:0]      level,
	input  logic                             line_raised,
	input  logic [pia_pkg::CODE_W-1:0]       event_code,
	input  logic [pia_pkg::MASK_W-1:0]       mask_level,
	input  logic                             block_bit,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pia_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pia_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             done,
	output logic                             taken,
	output logic [pia_pkg::LEVEL_W-1:0]      taken_level,
	output logic [pia_pkg::CODE_W-1:0]       taken_code,
	output logic [pia_pkg::ADDR_W-1:0]       handler_address,
	output logic                             mode_error,
	output logic                             pending,
	output logic                             nmi_flag
);
	import pia_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	cfg_t  cfg;
	res_t  res;
	logic  done_s2;
	res_t  res_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	pia_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1.action      <= action;
			item_s1.level       <= level;
			item_s1.line_raised <= line_raised;
			item_s1.event_code  <= event_code;
			item_s1.mask_level  <= mask_level;
			item_s1.block_bit   <= block_bit;
		end
		if (valid_s1) begin
			res_s2 <= res;
		end
	end

	pia_levels #(
		.NUM_LEVELS (NUM_LEVELS)
	) u_levels (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign done            = done_s2;
	assign taken           = res_s2.taken;
	assign taken_level     = res_s2.taken_level;
	assign taken_code      = res_s2.taken_code;
	assign handler_address = res_s2.handler_address;
	assign mode_error      = res_s2.mode_error;
	assign pending         = res_s2.pending;
	assign nmi_flag        = res_s2.nmi_flag;

	a_word_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##1 done)
		else $error("result strobe missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without word");

	a_take_xor_err: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(taken && mode_error))
		else $error("taken and mode error together");

endmodule
